/* hdl/limit_order_matching_engine_assert.svh */
// Assertion macros for the limit order matching engine.
`ifndef LIMIT_ORDER_MATCHING_ENGINE_ASSERT_SVH
`define LIMIT_ORDER_MATCHING_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define LOME_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LOME_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LOME_ASSERT_IMP(label, clk, rst, ante, cons)
`define LOME_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/lome_pkg.sv */
// ---------------------------------------------------------------------------
// lome_pkg
// Types, constants and control codes shared by the matching engine modules.
// ---------------------------------------------------------------------------
`default_nettype none
package lome_pkg;
   localparam int OrderIds   = 65536;
   localparam int BookDepth  = 4096;
   localparam int NumStocks  = 5;
   localparam int IdW        = $clog2(OrderIds);
   localparam int BookW      = $clog2(BookDepth);
   localparam int CntW       = BookW + 1;
   localparam int StkW       = $clog2(NumStocks) > 0 ? $clog2(NumStocks) : 1;
   localparam logic [19:0] NoTradeYet = 20'd1000001;

   localparam logic [2:0] FuncBuy    = 3'd0;
   localparam logic [2:0] FuncSell   = 3'd1;
   localparam logic [2:0] FuncCancel = 3'd2;
   localparam logic [2:0] FuncQuery  = 3'd3;
   localparam logic [2:0] FuncClear  = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] order_id;
      logic [2:0]  stock_index;
      logic [15:0] quantity;
      logic [19:0] limit_price;
   } req_type;

   typedef struct packed {
      logic [15:0] unfilled_quantity;
      logic [19:0] best_profit;
      logic        book_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_SCAN, ST_SCAN_WAIT, ST_FILL_RD, ST_FILL,
      ST_REST, ST_RESPOND
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic latch;      // capture request
      logic clr_step;   // clear one remaining entry, advance clear pointer
      logic clr_start;  // reset clear pointer and statistics
      logic scan_start; // reset scan pointer and best candidate
      logic scan_step;  // evaluate entry under scan pointer, advance
      logic fill_rd;    // read remaining of best
      logic fill;       // apply fill
      logic rest;       // append remainder
      logic cancel;     // zero remaining of request id
      logic respond;    // drive result strobe
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clr_done;
      logic scan_done;
      logic found;
      logic qty_zero;
      logic stock_ok;
      logic [2:0] func;
   } stat_type;
endpackage
`default_nettype wire

/* hdl/lome_ctrl.sv */
// ---------------------------------------------------------------------------
// lome_ctrl
// Sequencer: clearing pass, scan/fill loop, rest and respond.
// ---------------------------------------------------------------------------
`default_nettype none
`include "limit_order_matching_engine_assert.svh"
module lome_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output lome_pkg::cmd_type       cmd,
   input  wire lome_pkg::stat_type stat
);
   import lome_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         // A requested clear answers once the pass ends; the reset pass does not.
         ST_CLEAR:     if (stat.clr_done) state_in = (stat.func == FuncClear) ? ST_RESPOND : ST_IDLE;
         ST_IDLE:      if (start) state_in = ST_DECODE;
         ST_DECODE: begin
            if ((stat.func == FuncBuy || stat.func == FuncSell) && stat.stock_ok) begin
               state_in = stat.qty_zero ? ST_RESPOND : ST_SCAN;
            end else if (stat.func == FuncClear) begin
               state_in = ST_CLEAR;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_SCAN:      if (stat.scan_done) state_in = ST_SCAN_WAIT;
         ST_SCAN_WAIT: state_in = stat.found ? ST_FILL_RD : ST_REST;
         ST_FILL_RD:   state_in = ST_FILL;
         ST_FILL:      state_in = ST_REST;
         ST_REST:      state_in = ST_RESPOND;
         ST_RESPOND:   state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
      // After a fill, loop back to scan while quantity remains.
      if (state_ff == ST_FILL && !stat.qty_zero) state_in = ST_SCAN;
      if (state_ff == ST_FILL && stat.qty_zero) state_in = ST_RESPOND;
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR:   cmd.clr_step = 1'b1;
         ST_IDLE:    cmd.latch = start;
         ST_DECODE: begin
            cmd.scan_start = 1'b1;
            cmd.clr_start  = (stat.func == FuncClear);
            cmd.cancel     = (stat.func == FuncCancel);
         end
         ST_SCAN:    cmd.scan_step = 1'b1;
         ST_FILL_RD: cmd.fill_rd = 1'b1;
         ST_FILL: begin
            cmd.fill = 1'b1;
            cmd.scan_start = 1'b1;
         end
         ST_REST:    cmd.rest = 1'b1;
         ST_RESPOND: cmd.respond = 1'b1;
         default:    cmd = '0;
      endcase
   end

   `LOME_ASSERT_NXT(a_accept_goes_decode, clock, reset, state_ff == ST_IDLE && start, state_ff == ST_DECODE)
   `LOME_ASSERT_NXT(a_respond_to_idle, clock, reset, state_ff == ST_RESPOND, state_ff == ST_IDLE)
   `LOME_ASSERT_IMP(a_busy_unless_idle, clock, reset, state_ff != ST_IDLE, busy)
endmodule
`default_nettype wire

/* hdl/lome_datapath.sv */
// ---------------------------------------------------------------------------
// lome_datapath
// Order memory, book memory, scan comparator and trade statistics.
// ---------------------------------------------------------------------------
`default_nettype none
`include "limit_order_matching_engine_assert.svh"
module lome_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lome_pkg::req_type  req_data,
   input  wire lome_pkg::cmd_type  cmd,
   output lome_pkg::stat_type      stat,
   output lome_pkg::rsp_type       rsp_data
);
   import lome_pkg::*;

   localparam int EntW = IdW + 20 + StkW + 1;

   logic [15:0]     rem_mem [OrderIds];
   logic [EntW-1:0] book_mem [BookDepth];

   req_type         req_ff;
   logic [15:0]     qty_ff;
   logic [CntW-1:0] count_ff;
   logic [IdW:0]    clr_ptr_ff;
   logic [19:0]     low_ff  [NumStocks];
   logic [19:0]     prof_ff [NumStocks];
   logic            full_ff;

   // Scan pipeline: stage 0 reads book, stage 1 reads remaining, stage 2 compares.
   logic [CntW-1:0] scan_ptr_ff;
   logic            v1_ff, v2_ff;
   logic [EntW-1:0] ent_ff;
   logic [EntW-1:0] ent2_ff;
   logic [15:0]     rem2_ff;
   logic            found_ff;
   logic [IdW-1:0]  best_id_ff;
   logic [19:0]     best_price_ff;
   logic [15:0]     avail_ff;

   logic            stock_ok;
   logic [StkW-1:0] s_idx;
   logic            is_sell;
   logic [IdW-1:0]  req_id;

   assign stock_ok = req_ff.stock_index >= 3'd1 && {29'd0, req_ff.stock_index} <= NumStocks;
   assign s_idx    = StkW'(req_ff.stock_index - 3'd1);
   assign is_sell  = (req_ff.func == FuncSell);
   assign req_id   = IdW'(req_ff.order_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= '0;
         qty_ff <= '0;
      end else if (cmd.latch) begin
         req_ff <= req_data;
         qty_ff <= req_data.quantity;
      end else if (cmd.fill) begin
         qty_ff <= (avail_ff <= qty_ff) ? qty_ff - avail_ff : 16'd0;
      end
   end

   // Entry fields.
   logic [IdW-1:0]  e_id;
   logic [19:0]     e_price;
   logic [StkW-1:0] e_stk;
   logic            e_side;
   assign {e_id, e_price, e_stk, e_side} = ent2_ff;

   logic scanning;
   assign scanning = scan_ptr_ff < count_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         scan_ptr_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         v1_ff <= scanning;
         if (scanning) scan_ptr_ff <= scan_ptr_ff + 1'b1;
         v2_ff <= v1_ff;
         if (v2_ff && e_stk == s_idx && e_side != is_sell && rem2_ff != 16'd0 &&
             (is_sell ? e_price >= req_ff.limit_price : e_price <= req_ff.limit_price) &&
             (!found_ff || (is_sell ? e_price > best_price_ff : e_price < best_price_ff))) begin
            found_ff      <= 1'b1;
            best_id_ff    <= e_id;
            best_price_ff <= e_price;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= book_mem[scan_ptr_ff[BookW-1:0]];
      ent2_ff <= ent_ff;
      rem2_ff <= rem_mem[ent_ff[EntW-1 -: IdW]];
      avail_ff <= rem_mem[best_id_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) rem_mem[clr_ptr_ff[IdW-1:0]] <= 16'd0;
      else if (cmd.cancel) rem_mem[req_id] <= 16'd0;
      else if (cmd.fill)
         rem_mem[best_id_ff] <= (avail_ff <= qty_ff) ? 16'd0 : avail_ff - qty_ff;
      else if (cmd.rest && qty_ff != 16'd0 && count_ff < CntW'(BookDepth))
         rem_mem[req_id] <= qty_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rest && qty_ff != 16'd0 && count_ff < CntW'(BookDepth))
         book_mem[count_ff[BookW-1:0]] <= {req_id, req_ff.limit_price, s_idx, is_sell};
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) begin
         clr_ptr_ff <= '0;
         count_ff   <= '0;
         for (int i = 0; i < NumStocks; i++) begin
            low_ff[i]  <= NoTradeYet;
            prof_ff[i] <= 20'd0;
         end
      end else begin
         if (cmd.clr_step && !clr_ptr_ff[IdW]) clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (cmd.rest && qty_ff != 16'd0 && count_ff < CntW'(BookDepth))
            count_ff <= count_ff + 1'b1;
         if (cmd.fill) begin
            if (best_price_ff < low_ff[s_idx]) low_ff[s_idx] <= best_price_ff;
            else if (best_price_ff - low_ff[s_idx] > prof_ff[s_idx])
               prof_ff[s_idx] <= best_price_ff - low_ff[s_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) full_ff <= 1'b0;
      else if (cmd.rest) full_ff <= (qty_ff != 16'd0) && (count_ff >= CntW'(BookDepth));
   end

   assign stat.clr_done  = clr_ptr_ff[IdW];
   assign stat.scan_done = !scanning && !v1_ff && !v2_ff && !cmd.scan_start;
   assign stat.found     = found_ff;
   assign stat.qty_zero  = cmd.fill ? (avail_ff >= qty_ff) : (qty_ff == 16'd0);
   assign stat.stock_ok  = stock_ok;
   assign stat.func      = req_ff.func;

   logic trade_fn;
   assign trade_fn = (req_ff.func == FuncBuy || req_ff.func == FuncSell) && stock_ok;
   always_comb begin
      rsp_data.unfilled_quantity = trade_fn ? qty_ff : 16'd0;
      rsp_data.best_profit = (req_ff.func == FuncQuery && stock_ok) ? prof_ff[s_idx] : 20'd0;
      rsp_data.book_full = trade_fn & full_ff;
   end

   `LOME_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(BookDepth))
   `LOME_ASSERT_NXT(a_rest_grows, clock, reset, cmd.rest && qty_ff != 16'd0 && count_ff < CntW'(BookDepth), count_ff == $past(count_ff) + 1'b1)
   `LOME_ASSERT_IMP(a_full_needs_count, clock, reset, full_ff && cmd.respond, count_ff == CntW'(BookDepth))
endmodule
`default_nettype wire

/* hdl/limit_order_matching_engine.sv */
// Buy or sell: decode, scan, then per match a fill read and fill with a rescan while
//   quantity remains, then rest and respond; a fill that empties the order goes straight
//   to respond. Each scan walks the entries through one read port.
// Cancel, query, unused func: decode, then respond. Clear: decode, a memory pass, respond.
// One request in flight; reset runs the same clearing pass with busy held high.
// One result strobe per accepted request, clear included; the receiver cannot stall.
// ---------------------------------------------------------------------------
// limit_order_matching_engine
// Top level: sequencer plus datapath for a small limit order book.
// ---------------------------------------------------------------------------
`default_nettype none
module limit_order_matching_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lome_pkg::req_type req_data,
   output logic                   rsp_valid,
   output lome_pkg::rsp_type      rsp_data
);
   import lome_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer drives commands, datapath reports status.
   lome_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .cmd (cmd), .stat (stat)
   );

   lome_datapath u_dp (
      .clock (clock), .reset (reset), .req_data (req_data),
      .cmd (cmd), .stat (stat), .rsp_data (rsp_data)
   );

   // Strobe the result for one cycle.
   assign rsp_valid = cmd.respond;
endmodule
`default_nettype wire

/* bench/limit_order_matching_engine_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// limit_order_matching_engine_tb
// Self-checking bench for the order book matching engine. A scoreboard class
// keeps its own copy of the book and predicts one result per accepted
// request. Requests go in through start/busy in random bursts. Every result
// strobe is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none
module limit_order_matching_engine_tb;
   import lome_pkg::*;

   localparam int HalfPeriod = 5;
   localparam int CycleLimit = 3000000;
   localparam int RandomItems = 140;
   localparam logic [19:0] MaxPrice = 20'd1000000;

   // One resting order as the scoreboard keeps it.
   typedef struct {
      logic [15:0] id;
      logic [19:0] price;
      int          stock;
      logic        side;
   } resting_order_type;

   // Shadow order book: applies each accepted request and queues the answer.
   class order_book_scoreboard;
      logic [15:0]       remaining [OrderIds];
      resting_order_type book [$];
      logic [19:0]       lowest [NumStocks];
      logic [19:0]       profit [NumStocks];
      rsp_type           pending [$];
      int                errors;
      int                fills;
      int                rests;
      int                checked;

      function new();
         errors = 0;
         fills = 0;
         rests = 0;
         checked = 0;
         wipe_book();
      endfunction

      function void wipe_book();
         foreach (remaining[i]) remaining[i] = '0;
         book.delete();
         for (int s = 0; s < NumStocks; s++) begin
            lowest[s] = NoTradeYet;
            profit[s] = '0;
         end
      endfunction

      // Index of the best crossing opposite order, or -1.
      function int best_match(int s, logic sell, logic [19:0] limit);
         int best;
         best = -1;
         for (int i = 0; i < book.size(); i++) begin
            if (book[i].stock != s || book[i].side == sell) continue;
            if (remaining[book[i].id] == 0) continue;
            if (sell ? (book[i].price < limit) : (book[i].price > limit)) continue;
            if (best < 0) best = i;
            else if (sell ? (book[i].price > book[best].price)
                          : (book[i].price < book[best].price)) best = i;
         end
         return best;
      endfunction

      function void note_request(req_type r);
         rsp_type     ans;
         logic [15:0] qty;
         logic [15:0] avail;
         logic [19:0] px;
         logic        sell;
         logic        stock_ok;
         int          s;
         int          b;
         ans = '0;
         stock_ok = (r.stock_index >= 1 && r.stock_index <= NumStocks);
         s = int'(r.stock_index) - 1;
         if ((r.func == FuncBuy || r.func == FuncSell) && stock_ok) begin
            sell = (r.func == FuncSell);
            qty = r.quantity;
            while (qty != 0) begin
               b = best_match(s, sell, r.limit_price);
               if (b < 0) break;
               avail = remaining[book[b].id];
               if (avail <= qty) begin
                  qty -= avail;
                  remaining[book[b].id] = '0;
               end else begin
                  remaining[book[b].id] = avail - qty;
                  qty = '0;
               end
               fills++;
               // Track the low, or else the best gain over it.
               px = book[b].price;
               if (px < lowest[s]) lowest[s] = px;
               else if (px - lowest[s] > profit[s]) profit[s] = px - lowest[s];
            end
            if (qty != 0) begin
               if (book.size() < BookDepth) begin
                  book.push_back('{r.order_id, r.limit_price, s, sell});
                  remaining[r.order_id] = qty;
                  rests++;
               end else begin
                  ans.book_full = 1'b1;
               end
            end
            ans.unfilled_quantity = qty;
         end else if (r.func == FuncCancel) begin
            remaining[r.order_id] = '0;
         end else if (r.func == FuncQuery && stock_ok) begin
            ans.best_profit = profit[s];
         end else if (r.func == FuncClear) begin
            wipe_book();
         end
         pending.push_back(ans);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result unfilled=%0d profit=%0d full=%0d", $time,
                     got.unfilled_quantity, got.best_profit, got.book_full);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.unfilled_quantity !== want.unfilled_quantity) begin
            $display("%0t: unfilled_quantity expected %0d actual %0d", $time,
                     want.unfilled_quantity, got.unfilled_quantity);
            errors++;
         end
         if (got.best_profit !== want.best_profit) begin
            $display("%0t: best_profit expected %0d actual %0d", $time,
                     want.best_profit, got.best_profit);
            errors++;
         end
         if (got.book_full !== want.book_full) begin
            $display("%0t: book_full expected %0d actual %0d", $time,
                     want.book_full, got.book_full);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   order_book_scoreboard book_sb;
   int cycles = 0;
   int clears_left = 2;
   int queries = 0;

   limit_order_matching_engine dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #HalfPeriod clock = ~clock;

   // Check every strobed result; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid) book_sb.check_result(rsp_data);
   end

   // Watchdog: the post-reset and clear passes dominate, so allow a wide margin.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present the request at a falling edge and hold it until busy is low at a
   // falling edge; the next rising edge completes the transfer. Start stays
   // high afterwards, which is safe since busy rises at that same edge.
   task automatic send(logic [2:0] func, logic [15:0] id, logic [2:0] stock,
                       logic [15:0] qty, logic [19:0] price);
      req_type r;
      r.func = func;
      r.order_id = id;
      r.stock_index = stock;
      r.quantity = qty;
      r.limit_price = price;
      if (func == FuncQuery) queries++;
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      while (busy) @(negedge clock);
      book_sb.note_request(r);
      @(posedge clock);
   endtask

   // Drop start for a number of cycles between bursts.
   task automatic idle(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Price near a common level so orders cross often, with rare extremes.
   function automatic logic [19:0] pick_price();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return '0;
      if (k == 1) return MaxPrice;
      if (k == 2) return 20'($urandom);
      return 20'(500000 + $urandom_range(0, 40) * 100 - 2000);
   endfunction

   function automatic logic [15:0] pick_qty();
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return '0;
      if (k == 1) return 16'($urandom);
      return 16'($urandom_range(1, 40));
   endfunction

   function automatic logic [15:0] pick_id();
      // Mostly a small pool so ids get reused, cancelled and revived.
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 15));
   endfunction

   function automatic logic [2:0] pick_stock();
      if ($urandom_range(0, 14) == 0) return 3'($urandom);
      return 3'($urandom_range(1, 3));
   endfunction

   task automatic random_item();
      int k;
      logic [2:0] f;
      k = $urandom_range(0, 99);
      if (k < 40) f = FuncBuy;
      else if (k < 80) f = FuncSell;
      else if (k < 88) f = FuncCancel;
      else if (k < 95) f = FuncQuery;
      else if (k < 97 && clears_left > 0) begin
         f = FuncClear;
         clears_left--;
      end else f = 3'(FuncClear + $urandom_range(1, 3));
      send(f, pick_id(), pick_stock(), pick_qty(), pick_price());
   endtask

   initial begin
      int sent;
      int burst;
      book_sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: quantity zero, rest, partial fill, oldest-first at equal price.
      send(FuncBuy, 16'd1, 3'd1, 16'd0, 20'd100);
      send(FuncSell, 16'd2, 3'd1, 16'd10, 20'd200);
      send(FuncSell, 16'd3, 3'd1, 16'd5, 20'd200);
      send(FuncSell, 16'd4, 3'd1, 16'd7, 20'd150);
      send(FuncBuy, 16'd5, 3'd1, 16'd12, 20'd200);
      send(FuncBuy, 16'd6, 3'd1, 16'd20, 20'd300);
      // Shared id: new rest revives an older entry with the same id.
      send(FuncSell, 16'd6, 3'd1, 16'd3, 20'd250);
      send(FuncCancel, 16'd6, 3'd1, 16'd0, 20'd0);
      send(FuncSell, 16'd6, 3'd1, 16'd4, 20'd260);
      send(FuncBuy, 16'd7, 3'd1, 16'd30, MaxPrice);
      send(FuncQuery, 16'd0, 3'd1, 16'd0, 20'd0);
      // Extremes of the fields and bad stocks.
      send(FuncSell, 16'hFFFF, 3'd5, 16'hFFFF, 20'hFFFFF);
      send(FuncBuy, 16'hFFFF, 3'd5, 16'hFFFF, 20'hFFFFF);
      send(FuncBuy, 16'd8, 3'd5, 16'd1, 20'd0);
      send(FuncSell, 16'd9, 3'd5, 16'd1, 20'd0);
      send(FuncQuery, 16'd0, 3'd5, 16'd0, 20'd0);
      send(FuncBuy, 16'd10, 3'd0, 16'd5, 20'd5);
      send(FuncSell, 16'd10, 3'd6, 16'd5, 20'd5);
      send(FuncQuery, 16'd0, 3'd0, 16'd0, 20'd0);
      send(FuncQuery, 16'd0, 3'd7, 16'd0, 20'd0);
      for (int u = 1; u <= 3; u++) send(3'(FuncClear + u), 16'd1, 3'd1, 16'd1, 20'd1);
      send(FuncClear, 16'd0, 3'd0, 16'd0, 20'd0);
      send(FuncQuery, 16'd0, 3'd1, 16'd0, 20'd0);

      // Random bursts with random gaps, sometimes none.
      sent = 0;
      while (sent < RandomItems) begin
         burst = $urandom_range(1, 10);
         for (int i = 0; i < burst && sent < RandomItems; i++) begin
            random_item();
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(0, 6));
      end
      idle(1);

      // Drain, then allow a few more cycles for stray strobes.
      while (book_sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d results: %0d fills, %0d resting orders, %0d queries.",
               book_sb.checked, book_sb.fills, book_sb.rests, queries);
      if (book_sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
+incdir+hdl
hdl/lome_pkg.sv
hdl/lome_ctrl.sv
hdl/lome_datapath.sv
hdl/limit_order_matching_engine.sv
bench/limit_order_matching_engine_tb.sv
